### rtl/htb_pkg.sv
// Shared types and constants for the hex text to bytes parser.
// No dependencies; imported by every module of the block.
package htb_pkg;

    // Input commands
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_CHAR  = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;

    // Finish status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHR = 2'd1;
    localparam logic [1:0] STATUS_ODD     = 2'd2;

    // Character codes the scanner reacts to
    localparam logic [7:0] CH_SEMI    = 8'h3b;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_STAR    = 8'h2a;
    localparam logic [7:0] CH_DIG_LO  = 8'h30;
    localparam logic [7:0] CH_DIG_HI  = 8'h39;
    localparam logic [7:0] CH_UC_LO   = 8'h41;
    localparam logic [7:0] CH_UC_HI   = 8'h46;
    localparam logic [7:0] CH_LC_LO   = 8'h61;
    localparam logic [7:0] CH_LC_HI   = 8'h66;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0d;

    localparam logic [15:0] MAX_LENGTH_RESET = 16'hffff;

    // Scanner mode, one-hot
    typedef enum logic [5:0] {
        MODE_NORMAL = 6'b000001,
        MODE_LINE   = 6'b000010,
        MODE_SLASH  = 6'b000100,
        MODE_BLOCK  = 6'b001000,
        MODE_STAR   = 6'b010000,
        MODE_DONE   = 6'b100000
    } mode_t;

    // Scanner state apart from the byte counter
    typedef struct packed {
        mode_t      mode;
        logic       half;
        logic [3:0] nib;
    } scan_state_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] ch;
    } in_t;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic        finished;
        logic [1:0]  status;
        logic [15:0] byte_count;
    } out_t;

endpackage

### rtl/htb_step.sv
// Next-state and result logic for one input item of the hex parser.
// Depends on htb_pkg; pure combinational, used by the top level.
module htb_step
    import htb_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  in_t                     item,
    input  scan_state_t             st,
    input  logic [COUNT_BITS-1:0]   cnt,
    input  logic [15:0]             max_length,
    output scan_state_t             st_next,
    output logic [COUNT_BITS-1:0]   cnt_next,
    output logic                    res_valid,
    output out_t                    res
);

    // Hex digit decode: bit 4 flags a digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CH_DIG_LO && c <= CH_DIG_HI)
            r = {1'b1, 4'(c - CH_DIG_LO)};
        else if (c >= CH_UC_LO && c <= CH_UC_HI)
            r = {1'b1, 4'(c - CH_UC_LO + 8'd10)};
        else if (c >= CH_LC_LO && c <= CH_LC_HI)
            r = {1'b1, 4'(c - CH_LC_LO + 8'd10)};
        return r;
    endfunction

    logic [COUNT_BITS+15:0] cnt_ext;
    logic [COUNT_BITS+15:0] inc_ext;
    logic [COUNT_BITS+15:0] max_ext;
    logic [COUNT_BITS-1:0]  cnt_inc;
    logic                   over_limit;
    logic                   inc_fin;
    logic                   is_space;
    logic [4:0]             digit;

    // Counter compares in a width that holds both operands
    assign cnt_inc    = cnt + COUNT_BITS'(1);
    assign cnt_ext    = {16'b0, cnt};
    assign inc_ext    = {16'b0, cnt_inc};
    assign max_ext    = {{COUNT_BITS{1'b0}}, max_length};
    assign over_limit = cnt_ext >= max_ext;
    assign inc_fin    = (inc_ext >= max_ext) || (&cnt_inc);
    assign is_space   = (item.ch == CH_SPACE) || (item.ch >= CH_TAB && item.ch <= CH_CR);
    assign digit      = hex_digit(item.ch);

    always_comb
    begin
        st_next        = st;
        cnt_next       = cnt;
        res_valid      = 1'b0;
        res            = '0;
        res.byte_count = cnt_ext[15:0];

        case (item.cmd)
            CMD_START:
            begin
                st_next.mode = MODE_NORMAL;
                st_next.half = 1'b0;
                st_next.nib  = 4'd0;
                cnt_next     = '0;
                res.byte_count = 16'd0;
                if (max_length == 16'd0)
                begin
                    res_valid    = 1'b1;
                    res.finished = 1'b1;
                    st_next.mode = MODE_DONE;
                end
            end
            CMD_CHAR, CMD_END:
            begin
                if (st.mode != MODE_DONE)
                begin
                    if (item.cmd == CMD_END || over_limit)
                    begin
                        // plain finish: odd status if a digit waits
                        res_valid    = 1'b1;
                        res.finished = 1'b1;
                        res.status   = st.half ? STATUS_ODD : STATUS_OK;
                        st_next.mode = MODE_DONE;
                    end
                    else
                    begin
                        case (st.mode)
                            MODE_LINE:
                            begin
                                if (item.ch == CH_NEWLINE)
                                    st_next.mode = MODE_NORMAL;
                            end
                            MODE_SLASH:
                            begin
                                if (item.ch == CH_SLASH)
                                    st_next.mode = MODE_LINE;
                                else if (item.ch == CH_STAR)
                                    st_next.mode = MODE_STAR;
                                else
                                    st_next.mode = MODE_NORMAL;
                            end
                            MODE_BLOCK:
                            begin
                                if (item.ch == CH_STAR)
                                    st_next.mode = MODE_STAR;
                            end
                            MODE_STAR:
                            begin
                                if (item.ch == CH_SLASH)
                                    st_next.mode = MODE_NORMAL;
                                else if (item.ch != CH_STAR)
                                    st_next.mode = MODE_BLOCK;
                            end
                            MODE_NORMAL:
                            begin
                                if (item.ch == CH_SEMI)
                                begin
                                    res_valid    = 1'b1;
                                    res.finished = 1'b1;
                                    res.status   = st.half ? STATUS_ODD : STATUS_OK;
                                    st_next.mode = MODE_DONE;
                                end
                                else if (is_space)
                                begin
                                    st_next.mode = MODE_NORMAL;
                                end
                                else if (item.ch == CH_HASH)
                                begin
                                    st_next.mode = MODE_LINE;
                                end
                                else if (item.ch == CH_SLASH)
                                begin
                                    st_next.mode = MODE_SLASH;
                                end
                                else if (!digit[4])
                                begin
                                    res_valid    = 1'b1;
                                    res.finished = 1'b1;
                                    res.status   = STATUS_BAD_CHR;
                                    st_next.mode = MODE_DONE;
                                end
                                else if (!st.half)
                                begin
                                    st_next.half = 1'b1;
                                    st_next.nib  = digit[3:0];
                                end
                                else
                                begin
                                    // second digit completes a byte
                                    st_next.half   = 1'b0;
                                    st_next.nib    = 4'd0;
                                    cnt_next       = cnt_inc;
                                    res_valid      = 1'b1;
                                    res.byte_valid = 1'b1;
                                    res.data_byte  = {st.nib, digit[3:0]};
                                    res.byte_index = cnt_ext[15:0];
                                    res.byte_count = inc_ext[15:0];
                                    res.finished   = inc_fin;
                                    if (inc_fin)
                                        st_next.mode = MODE_DONE;
                                end
                            end
                            default:
                            begin
                                st_next.mode = st.mode;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                st_next = st;
            end
        endcase
    end

endmodule

### rtl/hex_text_to_bytes_parser.sv
// Hex text to bytes parser, top level: state registers and output buffer.
// Depends on htb_pkg and htb_step.
//
// The parser takes one character item per clock cycle while in_stall is low;
// the result an item causes (a byte, a finish, or both) enters the output
// buffer as it is accepted. Each item is handled in one pass through the
// scanner logic between the state registers and a two-entry output buffer;
// in_stall rises only when both buffer entries hold results that the
// receiver has not taken. Items that cause no result take no buffer entry.
// Write max_length through the cfg port only while idle (not enforced).
module hex_text_to_bytes_parser
    import htb_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    scan_state_t            st_reg;
    scan_state_t            st_next;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  count_next;
    logic [15:0]            max_length_reg;
    logic                   res_valid;
    out_t                   res;
    out_t                   head_reg;
    out_t                   skid_reg;
    logic                   head_valid_reg;
    logic                   skid_valid_reg;
    logic                   accept;
    logic                   push;
    logic                   pop;

    assign accept    = in_valid && !in_stall;
    assign push      = accept && res_valid;
    assign pop       = head_valid_reg && !out_stall;
    assign in_stall  = skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;
    assign cfg_ready = 1'b1;

    htb_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .item       (in_data),
        .st         (st_reg),
        .cnt        (count_reg),
        .max_length (max_length_reg),
        .st_next    (st_next),
        .cnt_next   (count_next),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Scanner state and length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode    <= MODE_DONE;
            st_reg.half    <= 1'b0;
            st_reg.nib     <= 4'd0;
            count_reg      <= '0;
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else
        begin
            if (accept)
            begin
                st_reg    <= st_next;
                count_reg <= count_next;
            end
            if (cfg_valid && cfg_ready)
                max_length_reg <= cfg_data;
        end
    end

    // Output buffer occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!head_valid_reg || pop)
        begin
            head_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= skid_valid_reg && push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output buffer payload, kept in arrival order
    always_ff @(posedge clk)
    begin
        if (!head_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                head_reg <= skid_reg;
                if (push)
                    skid_reg <= res;
            end
            else if (push)
            begin
                head_reg <= res;
            end
        end
        else if (push)
        begin
            skid_reg <= res;
        end
    end

endmodule

### rtl/htb_checker.sv
// Port-level checks for the hex text to bytes parser, bound to the top level.
// Depends on htb_pkg and hex_text_to_bytes_parser.
module htb_checker
    import htb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input in_t         in_data,
    input logic        out_valid,
    input logic        out_stall,
    input out_t        out_data
);

    // A stalled input item stays put
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("input item changed while stalled");

    // A held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output item changed while stalled");

    // Input stalls only while a result is waiting
    a_stall_backed: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // Every result carries a byte or a finish, and errors only on finish
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.byte_valid || out_data.finished) &&
                      (out_data.status == STATUS_OK || out_data.finished))
        else $error("result with neither byte nor finish");

    // Byte count runs one ahead of the byte's index
    a_count_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.byte_valid |->
            out_data.byte_count == 16'(out_data.byte_index + 16'd1))
        else $error("byte count does not follow byte index");

endmodule

bind hex_text_to_bytes_parser htb_checker u_htb_checker (.*);

### test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for hex_text_to_bytes_parser: directed and random text jobs.
// Depends on htb_pkg and the parser RTL; results are checked against an in-bench decoder.
module tb_top;
    import htb_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int PHASE_ITEMS   = 250;
    localparam int PHASES        = 7;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_t         in_data;
    logic        out_valid;
    logic        out_stall;
    out_t        out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // Decoder state mirrored by the bench
    mode_t       dec_mode   = MODE_DONE;
    logic        dec_half   = 1'b0;
    logic [3:0]  dec_nib    = 4'd0;
    logic [15:0] dec_count  = 16'd0;
    logic [15:0] max_length = MAX_LENGTH_RESET;

    out_t awaited_outputs[$];
    int   mismatch_count = 0;
    int   items_sent     = 0;
    int   cycle_count    = 0;
    bit   calm           = 1'b0;

    hex_text_to_bytes_parser #(.COUNT_BITS(16)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("hex_text_to_bytes_parser verification failed");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Receiver back-pressure
    initial
    begin : stall_gen
        int len;
        out_stall = 1'b0;
        forever
        begin
            len = idle_gap();
            repeat (len)
            begin
                @(posedge clk);
                out_stall <= 1'b1;
            end
            len = $urandom_range(1, 12);
            repeat (len)
            begin
                @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Decode one accepted item; queues the result it causes, if any.
    // live is cleared for items the parser merely ignores.
    task automatic decode_item(input in_t it, output bit live);
        out_t r;
        bit   emit_r;
        int   hv;
        r      = '0;
        emit_r = 1'b0;
        live   = 1'b1;
        hv     = -1;
        if (it.ch >= CH_DIG_LO && it.ch <= CH_DIG_HI)
            hv = int'(it.ch) - int'(CH_DIG_LO);
        else if (it.ch >= CH_UC_LO && it.ch <= CH_UC_HI)
            hv = int'(it.ch) - int'(CH_UC_LO) + 10;
        else if (it.ch >= CH_LC_LO && it.ch <= CH_LC_HI)
            hv = int'(it.ch) - int'(CH_LC_LO) + 10;

        if (it.cmd == CMD_START)
        begin
            dec_half  = 1'b0;
            dec_nib   = 4'd0;
            dec_count = 16'd0;
            dec_mode  = MODE_NORMAL;
            emit_r    = (max_length == 16'd0);
            r.finished = emit_r;
        end
        else if (it.cmd == CMD_UNUSED || dec_mode == MODE_DONE)
        begin
            live = 1'b0;
        end
        else if (it.cmd == CMD_END || dec_count >= max_length ||
                 (dec_mode == MODE_NORMAL && it.ch == CH_SEMI))
        begin
            // plain finish: odd digit count if a nibble is waiting
            emit_r     = 1'b1;
            r.finished = 1'b1;
            r.status   = dec_half ? STATUS_ODD : STATUS_OK;
        end
        else
        begin
            case (dec_mode)
                MODE_LINE:
                    if (it.ch == CH_NEWLINE)
                        dec_mode = MODE_NORMAL;
                MODE_SLASH:
                    if (it.ch == CH_SLASH)
                        dec_mode = MODE_LINE;
                    else if (it.ch == CH_STAR)
                        dec_mode = MODE_STAR;
                    else
                        dec_mode = MODE_NORMAL;
                MODE_BLOCK:
                    if (it.ch == CH_STAR)
                        dec_mode = MODE_STAR;
                MODE_STAR:
                    if (it.ch == CH_SLASH)
                        dec_mode = MODE_NORMAL;
                    else if (it.ch != CH_STAR)
                        dec_mode = MODE_BLOCK;
                default:
                begin
                    if (it.ch == CH_SPACE || (it.ch >= CH_TAB && it.ch <= CH_CR))
                        ;
                    else if (it.ch == CH_HASH)
                        dec_mode = MODE_LINE;
                    else if (it.ch == CH_SLASH)
                        dec_mode = MODE_SLASH;
                    else if (hv < 0)
                    begin
                        emit_r     = 1'b1;
                        r.finished = 1'b1;
                        r.status   = STATUS_BAD_CHR;
                    end
                    else if (!dec_half)
                    begin
                        dec_nib  = hv[3:0];
                        dec_half = 1'b1;
                    end
                    else
                    begin
                        emit_r       = 1'b1;
                        r.byte_valid = 1'b1;
                        r.data_byte  = {dec_nib, hv[3:0]};
                        r.byte_index = dec_count;
                        dec_half     = 1'b0;
                        dec_nib      = 4'd0;
                        dec_count    = dec_count + 16'd1;
                        r.finished   = (dec_count >= max_length) || (dec_count == 16'hffff);
                    end
                end
            endcase
        end

        if (emit_r)
        begin
            r.byte_count = dec_count;
            if (r.finished)
                dec_mode = MODE_DONE;
            awaited_outputs.push_back(r);
        end
    endtask

    // Send one item; returns at the edge where it is taken, valid still high
    task automatic send_item(input in_t it);
        int  gap;
        bit  live;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        decode_item(it, live);
        if (live)
            items_sent++;
    endtask

    task automatic send_ch(input logic [7:0] c);
        in_t it;
        it.cmd = CMD_CHAR;
        it.ch  = c;
        send_item(it);
    endtask

    task automatic send_cmd(input logic [1:0] cmd);
        in_t it;
        it.cmd = cmd;
        it.ch  = 8'($urandom_range(0, 255));
        send_item(it);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_ch(s[i]);
    endtask

    // Sender holds off until every queued result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (awaited_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_length(input logic [15:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        max_length = value;
    endtask

    function automatic logic [7:0] rand_hex_digit();
        case ($urandom_range(0, 2))
            0:       return 8'(CH_DIG_LO + $urandom_range(0, 9));
            1:       return 8'(CH_UC_LO + $urandom_range(0, 5));
            default: return 8'(CH_LC_LO + $urandom_range(0, 5));
        endcase
    endfunction

    function automatic logic [7:0] rand_blank();
        if ($urandom_range(0, 1) == 0)
            return CH_SPACE;
        return 8'(CH_TAB + $urandom_range(0, 4));
    endfunction

    // Random comment body that never contains the closing character
    task automatic send_filler(input logic [7:0] stop);
        logic [7:0] c;
        int         n;
        n = $urandom_range(0, 6);
        repeat (n)
        begin
            c = 8'($urandom_range(0, 255));
            if (c == stop)
                c = CH_SPACE;
            send_ch(c);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin : result_check
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_outputs.size() == 0)
                flag_mismatch("result with none expected", 64'd0, 64'(out_data));
            else
            begin
                want = awaited_outputs.pop_front();
                if (want.byte_valid != out_data.byte_valid)
                    flag_mismatch("byte_valid", 64'(want.byte_valid),
                                  64'(out_data.byte_valid));
                if (want.data_byte != out_data.data_byte)
                    flag_mismatch("data_byte", 64'(want.data_byte),
                                  64'(out_data.data_byte));
                if (want.byte_index != out_data.byte_index)
                    flag_mismatch("byte_index", 64'(want.byte_index),
                                  64'(out_data.byte_index));
                if (want.finished != out_data.finished)
                    flag_mismatch("finished", 64'(want.finished),
                                  64'(out_data.finished));
                if (want.status != out_data.status)
                    flag_mismatch("status", 64'(want.status), 64'(out_data.status));
                if (want.byte_count != out_data.byte_count)
                    flag_mismatch("byte_count", 64'(want.byte_count),
                                  64'(out_data.byte_count));
            end
        end
    end

    task automatic flag_mismatch(input string what, input longint unsigned want_v,
                                 input longint unsigned got_v);
        if (mismatch_count < 10)
            $display("mismatch at %0t, %s: expected %0h, got %0h", $realtime, what,
                     want_v, got_v);
        mismatch_count++;
    endtask

    // Commands while no job is open, and the unused command code
    task automatic test_idle_commands();
        send_ch("5");
        send_cmd(CMD_END);
        send_cmd(CMD_UNUSED);
    endtask

    // Digits of every case, whitespace, each comment form, finishes
    task automatic test_basic_text();
        send_cmd(CMD_START);
        // "/*/" closes at once, "/5" drops the digit
        send_text("0aF9\t/*//5#3\n//x\n7;");
        send_cmd(CMD_START);
        send_ch(8'hff);
    endtask

    // max_length extremes and a limit lowered under an open job
    task automatic test_length_limits();
        write_max_length(16'd0);
        send_cmd(CMD_START);
        write_max_length(16'd1);
        send_cmd(CMD_START);
        send_text("c3");
        write_max_length(16'd100);
        send_cmd(CMD_START);
        send_text("010");
        write_max_length(16'd1);
        send_ch("4");
    endtask

    // One text job of random tokens, mostly well formed
    task automatic run_job(input int phase_end);
        int tokens;
        int pick;
        send_cmd(CMD_START);
        tokens = $urandom_range(1, 40);
        while (tokens > 0 && dec_mode != MODE_DONE && items_sent < phase_end)
        begin
            tokens--;
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                send_ch(rand_hex_digit());
                if ($urandom_range(0, 7) == 0)
                    send_ch(rand_blank());
                send_ch(rand_hex_digit());
            end
            else if (pick < 63)
                send_ch(rand_blank());
            else if (pick < 68)
            begin
                send_ch(CH_HASH);
                send_filler(CH_NEWLINE);
                send_ch(CH_NEWLINE);
            end
            else if (pick < 72)
            begin
                send_ch(CH_SLASH);
                send_ch(CH_SLASH);
                send_filler(CH_NEWLINE);
                send_ch(CH_NEWLINE);
            end
            else if (pick < 78)
            begin
                send_ch(CH_SLASH);
                send_ch(CH_STAR);
                if ($urandom_range(0, 3) != 0)
                begin
                    send_filler(CH_STAR);
                    repeat ($urandom_range(1, 2)) send_ch(CH_STAR);
                end
                send_ch(CH_SLASH);
            end
            else if (pick < 81)
            begin
                send_ch(CH_SLASH);
                send_ch(8'($urandom_range(0, 255)));
            end
            else if (pick < 85)
                send_ch(rand_hex_digit());
            else if (pick < 88)
                send_ch(8'($urandom_range(0, 255)));
            else if (pick < 92)
                send_ch(CH_SEMI);
            else if (pick < 94)
                send_cmd(CMD_END);
            else if (pick < 96)
                send_cmd(CMD_START);
            else if (pick < 98)
            begin
                // pause mid-job; sometimes move the limit under the open job
                if ($urandom_range(0, 2) == 0)
                    write_max_length(16'($urandom_range(0, 12)));
                else
                    wait_drained();
            end
            else
                send_ch(CH_SPACE);
        end
        if (dec_mode != MODE_DONE && $urandom_range(0, 3) != 0)
            send_cmd(CMD_END);
    endtask

    // Random jobs and bursts of raw items under several limits
    task automatic test_random_jobs();
        int          phase_end;
        logic [15:0] len;
        logic [1:0]  raw_cmd;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       len = MAX_LENGTH_RESET;
                1:       len = 16'd0;
                2:       len = 16'd1;
                3:       len = 16'($urandom_range(2, 6));
                4:       len = 16'($urandom_range(7, 40));
                5:       len = MAX_LENGTH_RESET;
                default: len = 16'($urandom_range(1, 12));
            endcase
            write_max_length(len);
            calm      = (phase == 5);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    repeat ($urandom_range(3, 10))
                    begin
                        raw_cmd = 2'($urandom_range(0, 3));
                        send_cmd(raw_cmd);
                    end
                end
                else
                    run_job(phase_end);
            end
            calm = 1'b0;
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = 16'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_commands();
        test_basic_text();
        test_length_limits();
        test_random_jobs();

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && awaited_outputs.size() == 0)
            $display("hex_text_to_bytes_parser verification clean");
        else
            $display("hex_text_to_bytes_parser verification failed");
        $finish;
    end

endmodule
